/* rtl/core/sfr_pkg.sv */
// sfr_pkg: types, codes and framing constants of the serial frame receiver
// no dependencies; imported by sfr_parse and serial_frame_receiver
package sfr_pkg;

	localparam logic [7:0] HEAD_BYTE     = 8'h3C;
	localparam logic [7:0] TAIL_BYTE     = 8'h0D;
	localparam logic [7:0] WAKE_TYPE     = 8'hC0;
	localparam logic [7:0] TYPE_BASE     = 8'h80;
	localparam logic [7:0] TYPE_LAST     = 8'h8A;
	localparam logic [7:0] POS_MAX       = 8'hFF;
	localparam logic [7:0] MAX_LEN_RESET = 8'd250;

	typedef enum logic [2:0] {
		ROLE_HEAD     = 3'd0,
		ROLE_TYPE     = 3'd1,
		ROLE_LENGTH   = 3'd2,
		ROLE_PAYLOAD  = 3'd3,
		ROLE_CHECKSUM = 3'd4,
		ROLE_TAIL     = 3'd5
	} role_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_TYPE = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_TAIL = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] payload_len;
		logic [7:0] payload_count;
		logic [7:0] position;
		logic       is_wake;
		logic       indicator;
	} parse_state_t;

	typedef struct packed {
		role_t      role;
		logic [7:0] pos;
		logic       accepted;
		logic       rejected;
		logic       frame_done;
		logic       wake_event;
		logic       indicator_on;
	} parse_result_t;

endpackage

/* rtl/core/sfr_parse.sv */
// sfr_parse: next-state and result logic for one received byte
// depends on sfr_pkg
module sfr_parse
	import sfr_pkg::*;
(
	input  parse_state_t  cur,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    max_len,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic ok;
	logic done;
	logic wake;
	role_t role;
	parse_state_t upd;

	always_comb begin
		upd  = cur;
		ok   = 1'b0;
		done = 1'b0;
		wake = 1'b0;
		role = ROLE_HEAD;
		unique case (cur.phase)
			PH_TYPE: begin
				role = ROLE_TYPE;
				if (rx_byte == WAKE_TYPE || (rx_byte > TYPE_BASE && rx_byte <= TYPE_LAST)) begin
					ok = 1'b1;
					upd.phase = PH_LEN;
					if (rx_byte == WAKE_TYPE) begin
						upd.is_wake   = 1'b1;
						upd.indicator = 1'b1;
					end
				end
			end
			PH_LEN: begin
				role = ROLE_LENGTH;
				if (rx_byte <= max_len) begin
					ok = 1'b1;
					upd.payload_len = rx_byte;
					upd.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				ok = 1'b1;
				if (cur.payload_count < cur.payload_len) begin
					role = ROLE_PAYLOAD;
					upd.payload_count = cur.payload_count + 8'd1;
				end else begin
					role = ROLE_CHECKSUM;
					upd.phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				role = ROLE_TAIL;
				if (rx_byte == TAIL_BYTE) begin
					ok   = 1'b1;
					done = 1'b1;
					if (cur.is_wake) begin
						wake = 1'b1;
						upd.indicator = 1'b0;
					end
				end
			end
			default: begin
				role = ROLE_HEAD;
				if (rx_byte == HEAD_BYTE) begin
					ok = 1'b1;
					upd.phase = PH_TYPE;
				end
			end
		endcase

		nxt = upd;
		if (!ok || done) begin
			nxt.phase         = PH_IDLE;
			nxt.payload_len   = 8'd0;
			nxt.payload_count = 8'd0;
			nxt.position      = 8'd0;
			nxt.is_wake       = 1'b0;
			if (!ok) begin
				nxt.indicator = 1'b0;
			end
		end else if (cur.position != POS_MAX) begin
			nxt.position = cur.position + 8'd1;
		end

		res.role         = role;
		res.pos          = cur.position;
		res.accepted     = ok;
		res.rejected     = !ok;
		res.frame_done   = done;
		res.wake_event   = wake;
		res.indicator_on = nxt.indicator;
	end

endmodule

/* rtl/core/serial_frame_receiver.sv */
// serial_frame_receiver: top level, input register, frame state and result register
// depends on sfr_pkg and sfr_parse
//
// Takes one received serial byte per item and reports, for each byte, its role in the
// frame (head 0x3C, type, length, payload, checksum, tail 0x0D), its position, whether it
// was accepted or broke the frame, frame completion, wake frames and the download
// indicator level. One result item per input item, in order. Throughput is one byte per
// clock while out_ready is high. The result passes through the input register, then the
// combinational parse step into the result register; out_ready low holds it there.
// The frame state update is combinational, so consecutive bytes follow without waiting
// on it. The length limit register resets to 250 and is written through the cfg channel,
// which is always ready.
module serial_frame_receiver
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] byte_role,
	output logic [7:0] frame_pos,
	output logic       accepted,
	output logic       rejected,
	output logic       frame_done,
	output logic       wake_event,
	output logic       indicator_on
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	parse_result_t res_s2;
	logic [7:0]    max_len_q;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;
	logic          adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	sfr_parse u_parse (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.payload_len   <= 8'd0;
			state_q.payload_count <= 8'd0;
			state_q.position      <= 8'd0;
			state_q.is_wake       <= 1'b0;
			state_q.indicator     <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_role    = res_s2.role;
	assign frame_pos    = res_s2.pos;
	assign accepted     = res_s2.accepted;
	assign rejected     = res_s2.rejected;
	assign frame_done   = res_s2.frame_done;
	assign wake_event   = res_s2.wake_event;
	assign indicator_on = res_s2.indicator_on;

`ifndef SYNTHESIS
	a_count_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.payload_count <= state_q.payload_len)
		else $error("payload count ran past length");

	a_ind_in_wake: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.indicator |-> state_q.is_wake)
		else $error("indicator lit outside a wake frame");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_nxt.frame_done |=> state_q.phase == PH_IDLE && state_q.position == 8'd0)
		else $error("parser not cleared after tail");

	a_wake_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wake_event |-> frame_done && !indicator_on && accepted)
		else $error("wake item without completed frame");
`endif

endmodule
